// File: hdl/gpps_pkg.sv
// ----------------------------------------------------------------------------
// gpps_pkg
// Shared types and constants for the Goldbach prime pair search unit.
// ----------------------------------------------------------------------------
package gpps_pkg;

  localparam int unsigned SMALL_W = 15;
  localparam int unsigned LARGE_W = 16;

  // Top level search sequencer
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_WAIT_LO,
    S_TEST_HI,
    S_WAIT_HI,
    S_DONE
  } search_state_t;

  // Trial division sequencer
  typedef enum logic [1:0] {
    P_IDLE,
    P_CHECK,
    P_WAIT
  } prime_state_t;

  typedef struct packed {
    logic start;
  } mod_req_t;

  typedef struct packed {
    logic done;
    logic zero;
  } mod_rsp_t;

  typedef struct packed {
    logic start;
  } prime_req_t;

  typedef struct packed {
    logic done;
    logic is_prime;
  } prime_rsp_t;

endpackage

// File: hdl/gpps_if.sv
// ----------------------------------------------------------------------------
// gpps channel interfaces
// Valid/ready channels for the number input and the prime pair result.
// ----------------------------------------------------------------------------
interface gpps_in_if #(
  parameter int unsigned WIDTH = 16
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface gpps_out_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [gpps_pkg::SMALL_W-1:0] small_prime;
  logic [gpps_pkg::LARGE_W-1:0] large_prime;

  modport source (output valid, output found, output small_prime, output large_prime,
                  input ready);
  modport sink   (input valid, input found, input small_prime, input large_prime,
                  output ready);
endinterface

// File: hdl/gpps_mod.sv
// ----------------------------------------------------------------------------
// gpps_mod
// Bit-serial restoring remainder unit: x mod d, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module gpps_mod #(
  parameter int unsigned WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gpps_pkg::mod_req_t req,
  input  logic [WIDTH-1:0]   x,
  input  logic [WIDTH-1:0]   d,
  output gpps_pkg::mod_rsp_t rsp
);
  import gpps_pkg::*;

  localparam int unsigned CNT_W = $clog2(WIDTH + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [WIDTH-1:0] sh_r, sh_nxt;
  logic [WIDTH-1:0] d_r, d_nxt;
  logic [WIDTH:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    d_nxt    = d_r;
    trial    = {rem_r, sh_r[WIDTH-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(WIDTH);
      rem_nxt  = '0;
      sh_nxt   = x;
      d_nxt    = d;
    end else if (busy_r) begin
      // shift in the next dividend bit, subtract when it fits
      if (trial >= {1'b0, d_r}) begin
        trial = trial - {1'b0, d_r};
      end
      rem_nxt = trial[WIDTH-1:0];
      sh_nxt  = {sh_r[WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    d_r   <= d_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.zero = (rem_r == '0);

endmodule

// File: hdl/gpps_prime.sv
// ----------------------------------------------------------------------------
// gpps_prime
// Trial division primality test: divisors from 2 while d*d <= x.
// ----------------------------------------------------------------------------
module gpps_prime #(
  parameter int unsigned WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gpps_pkg::prime_req_t req,
  input  logic [WIDTH-1:0]     x,
  output gpps_pkg::prime_rsp_t rsp
);
  import gpps_pkg::*;

  prime_state_t     state_r, state_nxt;
  logic [WIDTH-1:0] x_r, x_nxt;
  logic [WIDTH-1:0] d_r, d_nxt;
  logic [WIDTH+1:0] sq_r, sq_nxt;
  logic             done_r, done_nxt;
  logic             prime_r, prime_nxt;
  logic             too_small;
  logic             sq_over;
  mod_req_t         mod_req;
  mod_rsp_t         mod_rsp;

  assign too_small = (x_r < WIDTH'(2));
  assign sq_over   = (sq_r > {2'b00, x_r});

  gpps_mod #(.WIDTH(WIDTH)) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .x     (x_r),
    .d     (d_r),
    .rsp   (mod_rsp)
  );

  // next state and datapath
  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    d_nxt     = d_r;
    sq_nxt    = sq_r;
    done_nxt  = 1'b0;
    prime_nxt = prime_r;
    case (state_r)
      P_IDLE: begin
        if (req.start) begin
          x_nxt     = x;
          d_nxt     = WIDTH'(2);
          sq_nxt    = (WIDTH+2)'(4);
          state_nxt = P_CHECK;
        end
      end
      P_CHECK: begin
        if (too_small) begin
          done_nxt  = 1'b1;
          prime_nxt = 1'b0;
          state_nxt = P_IDLE;
        end else if (sq_over) begin
          done_nxt  = 1'b1;
          prime_nxt = 1'b1;
          state_nxt = P_IDLE;
        end else begin
          state_nxt = P_WAIT;
        end
      end
      P_WAIT: begin
        if (mod_rsp.done) begin
          if (mod_rsp.zero) begin
            done_nxt  = 1'b1;
            prime_nxt = 1'b0;
            state_nxt = P_IDLE;
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            sq_nxt    = sq_r + {1'b0, d_r, 1'b1};
            d_nxt     = d_r + 1'b1;
            state_nxt = P_CHECK;
          end
        end
      end
      default: begin
        state_nxt = P_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    mod_req.start = 1'b0;
    case (state_r)
      P_CHECK: mod_req.start = !too_small && !sq_over;
      default: mod_req.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= P_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    d_r     <= d_nxt;
    sq_r    <= sq_nxt;
    prime_r <= prime_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.is_prime = prime_r;

endmodule

// File: hdl/goldbach_prime_pair_search_unit.sv
// ----------------------------------------------------------------------------
// goldbach_prime_pair_search_unit
// Finds the first j >= 2 with j and n-j both prime for even n.
// ----------------------------------------------------------------------------
// Search: for odd n or n < 4 the number goes from S_CHECK straight to S_DONE;
//   otherwise each candidate j costs one primality test of j (and of n-j when
//   j is prime); each test runs the bit-serial remainder unit once per trial
//   divisor d with d*d <= x.
// Throughput: one number at a time; the next number is taken once the search
//   is done and the result sits in the output register. Reset: synchronous,
//   active low; clears the sequencers and the output valid.
module goldbach_prime_pair_search_unit #(
  parameter int unsigned WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  gpps_in_if.sink           in_ch,
  gpps_out_if.source        out_ch
);
  import gpps_pkg::*;

  search_state_t        state_r, state_nxt;
  logic [WIDTH-1:0]     n_r, n_nxt;
  logic [WIDTH-1:0]     j_r, j_nxt;
  logic                 res_found_r, res_found_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_found_r, out_found_nxt;
  logic [SMALL_W-1:0]   out_small_r, out_small_nxt;
  logic [LARGE_W-1:0]   out_large_r, out_large_nxt;
  logic [WIDTH-1:0]     hi_val;
  logic                 range_done;
  prime_req_t           prime_req;
  prime_rsp_t           prime_rsp;
  logic [WIDTH-1:0]     prime_x;

  assign hi_val     = n_r - j_r;
  assign range_done = n_r[0] || (j_r > (n_r >> 1));

  gpps_prime #(.WIDTH(WIDTH)) u_prime (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (prime_req),
    .x     (prime_x),
    .rsp   (prime_rsp)
  );

  // next state and datapath
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    j_nxt         = j_r;
    res_found_nxt = res_found_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_found_nxt = out_found_r;
    out_small_nxt = out_small_r;
    out_large_nxt = out_large_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          n_nxt     = in_ch.number;
          j_nxt     = WIDTH'(2);
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (range_done) begin
          res_found_nxt = 1'b0;
          state_nxt     = S_DONE;
        end else begin
          state_nxt = S_WAIT_LO;
        end
      end
      S_WAIT_LO: begin
        if (prime_rsp.done) begin
          if (prime_rsp.is_prime) begin
            state_nxt = S_TEST_HI;
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = S_CHECK;
          end
        end
      end
      S_TEST_HI: begin
        state_nxt = S_WAIT_HI;
      end
      S_WAIT_HI: begin
        if (prime_rsp.done) begin
          if (prime_rsp.is_prime) begin
            res_found_nxt = 1'b1;
            state_nxt     = S_DONE;
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = S_CHECK;
          end
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_small_nxt = res_found_r ? SMALL_W'(j_r) : '0;
          out_large_nxt = res_found_r ? LARGE_W'(hi_val) : '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready     = 1'b0;
    prime_req.start = 1'b0;
    prime_x         = j_r;
    case (state_r)
      S_IDLE:    in_ch.ready = 1'b1;
      S_CHECK:   prime_req.start = !range_done;
      S_TEST_HI: begin
        prime_req.start = 1'b1;
        prime_x         = hi_val;
      end
      default:   prime_req.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    j_r         <= j_nxt;
    res_found_r <= res_found_nxt;
    out_found_r <= out_found_nxt;
    out_small_r <= out_small_nxt;
    out_large_r <= out_large_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.small_prime = out_small_r;
  assign out_ch.large_prime = out_large_r;

endmodule

// File: hdl/gpps_checker.sv
// ----------------------------------------------------------------------------
// gpps_checker
// Port-level assertions for the Goldbach prime pair search unit.
// ----------------------------------------------------------------------------
module gpps_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_found,
  input logic [gpps_pkg::SMALL_W-1:0] out_small_prime,
  input logic [gpps_pkg::LARGE_W-1:0] out_large_prime
);
  import gpps_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_r, pend_nxt;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // count transactions taken but not yet delivered
  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend_nxt = pend_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out valid set right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) &&
      $stable(out_small_prime) && $stable(out_large_prime))
    else $error("stalled result changed");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_small_prime == '0 && out_large_prime == '0)
    else $error("result without a pair carries nonzero primes");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result shown with no transaction outstanding");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("more than two transactions outstanding");

endmodule

bind goldbach_prime_pair_search_unit gpps_checker u_gpps_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_found       (out_ch.found),
  .out_small_prime (out_ch.small_prime),
  .out_large_prime (out_ch.large_prime)
);

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives numbers into the Goldbach prime pair search unit and checks every
// returned pair against a fixed pair or a trial-division search in the bench.
// A short table of fixed numbers comes first, then random numbers, mostly small
// even ones, with random gaps on the input and random stalls on the result side.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gpps_pkg::*;

  localparam int unsigned WIDTH       = 16;
  localparam int unsigned RANDOM_NUMS = 80;
  localparam int unsigned DRAIN_CYCS  = 50;

  typedef struct {
    logic               found;
    logic [SMALL_W-1:0] small_prime;
    logic [LARGE_W-1:0] large_prime;
  } prime_pair_t;

  typedef struct {
    logic [WIDTH-1:0] number;
    bit               fixed;
    prime_pair_t      pair;
  } number_case_t;

  logic clk = 1'b0;
  logic rst_n;

  gpps_in_if #(.WIDTH(WIDTH)) in_if ();
  gpps_out_if                 out_if ();

  goldbach_prime_pair_search_unit #(.WIDTH(WIDTH)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  prime_pair_t  pending_pairs[$];
  number_case_t directed_cases[$];
  int unsigned  fail_count = 0;
  bit           sink_started = 1'b0;
  bit           quiet = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit has_no_divisor(input int unsigned x);
    int unsigned d;
    if (x < 2) return 1'b0;
    for (d = 2; d * d <= x; d++) begin
      if (x % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic prime_pair_t split_goldbach(input logic [WIDTH-1:0] n);
    prime_pair_t p;
    int unsigned j;
    int unsigned nv;
    p.found       = 1'b0;
    p.small_prime = '0;
    p.large_prime = '0;
    nv = n;
    if (n[0] == 1'b0) begin
      for (j = 2; j <= nv / 2; j++) begin
        if (has_no_divisor(j) && has_no_divisor(nv - j)) begin
          p.found       = 1'b1;
          p.small_prime = j[SMALL_W-1:0];
          p.large_prime = LARGE_W'(nv - j);
          break;
        end
      end
    end
    return p;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  task automatic add_case(input logic [WIDTH-1:0] n, input bit fixed, input logic f,
                          input int unsigned s, input int unsigned l);
    number_case_t c;
    c.number           = n;
    c.fixed            = fixed;
    c.pair.found       = f;
    c.pair.small_prime = s[SMALL_W-1:0];
    c.pair.large_prime = l[LARGE_W-1:0];
    directed_cases.push_back(c);
  endtask

  // Hold the number until the transaction completes, then record its pair.
  task automatic send_number(input logic [WIDTH-1:0] n, input prime_pair_t want,
                             input int unsigned gap);
    in_if.valid  <= 1'b1;
    in_if.number <= n;
    do @(posedge clk); while (!in_if.ready);
    pending_pairs.push_back(want);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result side: random ready with long stalls now and then.
  initial begin
    int unsigned r;
    int unsigned len;
    out_if.ready <= 1'b0;
    wait (sink_started);
    forever begin
      if (quiet) begin
        out_if.ready <= 1'b1;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 9);
        if (r < 6) begin
          out_if.ready <= 1'b1;
          len = $urandom_range(1, 8);
        end else if (r < 9) begin
          out_if.ready <= 1'b0;
          len = $urandom_range(1, 4);
        end else begin
          out_if.ready <= 1'b0;
          len = $urandom_range(30, 150);
        end
        repeat (len) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    prime_pair_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_pairs.size() == 0) begin
        $error("unexpected result: found %0d small_prime %0d large_prime %0d",
               out_if.found, out_if.small_prime, out_if.large_prime);
        fail_count++;
      end else begin
        want = pending_pairs.pop_front();
        if (out_if.found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, out_if.found);
          fail_count++;
        end
        if (out_if.small_prime !== want.small_prime) begin
          $error("small_prime: expected %0d, actual %0d", want.small_prime,
                 out_if.small_prime);
          fail_count++;
        end
        if (out_if.large_prime !== want.large_prime) begin
          $error("large_prime: expected %0d, actual %0d", want.large_prime,
                 out_if.large_prime);
          fail_count++;
        end
      end
    end
  end

  initial begin
    prime_pair_t      want;
    logic [WIDTH-1:0] n;
    int unsigned      r;
    int unsigned      i;

    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.number <= '0;

    // Below four and odd numbers give an empty pair.
    add_case(16'd0,     1'b1, 1'b0, 0, 0);
    add_case(16'd1,     1'b1, 1'b0, 0, 0);
    add_case(16'd2,     1'b1, 1'b0, 0, 0);
    add_case(16'd3,     1'b1, 1'b0, 0, 0);
    add_case(16'd4,     1'b1, 1'b1, 2, 2);
    add_case(16'd5,     1'b1, 1'b0, 0, 0);
    add_case(16'd6,     1'b1, 1'b1, 3, 3);
    add_case(16'd8,     1'b1, 1'b1, 3, 5);
    add_case(16'd10,    1'b1, 1'b1, 3, 7);
    add_case(16'd12,    1'b1, 1'b1, 5, 7);
    add_case(16'hFFFF,  1'b1, 1'b0, 0, 0);
    add_case(16'hFFFE,  1'b0, 1'b0, 0, 0);
    add_case(16'h8000,  1'b0, 1'b0, 0, 0);
    add_case(16'h7FFF,  1'b1, 1'b0, 0, 0);
    add_case(16'hAAAA,  1'b0, 1'b0, 0, 0);
    add_case(16'h5555,  1'b1, 1'b0, 0, 0);
    add_case(16'h5554,  1'b0, 1'b0, 0, 0);
    add_case(16'd98,    1'b0, 1'b0, 0, 0);
    add_case(16'd128,   1'b0, 1'b0, 0, 0);
    add_case(16'd1000,  1'b0, 1'b0, 0, 0);
    add_case(16'hFFFC,  1'b0, 1'b0, 0, 0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    sink_started = 1'b1;

    foreach (directed_cases[k]) begin
      want = directed_cases[k].fixed ? directed_cases[k].pair
                                     : split_goldbach(directed_cases[k].number);
      send_number(directed_cases[k].number, want, pick_gap());
    end

    // Keep most numbers small and even; large ones need many more trial divisions.
    for (i = 0; i < RANDOM_NUMS; i++) begin
      r = $urandom_range(0, 9);
      if (r < 7)      n = 16'($urandom_range(0, 511) * 2);
      else if (r < 8) n = 16'($urandom) & 16'hFFFE;
      else if (r < 9) n = 16'($urandom);
      else            n = 16'($urandom_range(0, 511) * 2 + 1);
      quiet = (i >= 40 && i < 60);
      send_number(n, split_goldbach(n), quiet ? 0 : pick_gap());
    end
    quiet = 1'b0;
    in_if.valid <= 1'b0;

    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCS) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS goldbach_prime_pair_search_unit");
    end else begin
      $display("FAIL goldbach_prime_pair_search_unit");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("FAIL goldbach_prime_pair_search_unit");
    $finish;
  end

endmodule

// File: files.f
hdl/gpps_pkg.sv
hdl/gpps_if.sv
hdl/gpps_mod.sv
hdl/gpps_prime.sv
hdl/goldbach_prime_pair_search_unit.sv
hdl/gpps_checker.sv
tb/testbench.sv
